>>> hdl/cpt_pkg.sv
// Shared types and constants for the contact pair table unit.
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ID_W          = 64;
    localparam int IDX_OUT_W     = 6;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] id_a;
        logic [ID_W-1:0] id_b;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] entry_index;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    scan;
        logic    finish;
        logic    write;
        t_status code;
    } t_dp_ctl;

    typedef struct packed {
        logic match;
        logic scan_end;
        logic bad;
        logic ensure;
        logic full;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/cpt_ctrl.sv
// Controller state machine that sequences normalize, scan and finish.
`timescale 1ns / 1ps
`default_nettype none

module cpt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire cpt_pkg::t_dp_stat  i_stat,
    output cpt_pkg::t_dp_ctl        o_ctl,
    output logic                    o_busy
);
    import cpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((i_stat.bad && i_stat.ensure) || i_stat.match || i_stat.scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.code = ST_NOT_FOUND;
        o_busy     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctl.load = i_start;
            end
            S_SCAN: begin
                o_busy = 1'b1;
                if (i_stat.bad && i_stat.ensure) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.code   = ST_INVALID;
                end else if (i_stat.match) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.code   = ST_FOUND;
                end else if (i_stat.scan_end) begin
                    o_ctl.finish = 1'b1;
                    if (!i_stat.ensure) begin
                        o_ctl.code = ST_NOT_FOUND;
                    end else if (i_stat.full) begin
                        o_ctl.code = ST_FULL;
                    end else begin
                        o_ctl.code  = ST_INSERTED;
                        o_ctl.write = 1'b1;
                    end
                end else begin
                    o_ctl.scan = 1'b1;
                end
            end
            default: o_busy = 1'b0;
        endcase
    end

    ap_finish_leaves_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> (r_state == S_IDLE))
        else $error("controller stayed busy after finishing a request");

    ap_load_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

    ap_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.write |-> (o_ctl.finish && i_stat.ensure && !i_stat.full && !i_stat.match))
        else $error("table write outside a legal insert");

endmodule

`default_nettype wire

>>> hdl/cpt_datapath.sv
// Datapath with the pair memory, scan pointer, comparator and result register.
`timescale 1ns / 1ps
`default_nettype none

module cpt_datapath #(
    parameter int TABLE_DEPTH = cpt_pkg::DEPTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cpt_pkg::t_req      i_req,
    input  wire cpt_pkg::t_dp_ctl   i_ctl,
    output cpt_pkg::t_dp_stat       o_stat,
    output cpt_pkg::t_rsp           o_rsp,
    output logic                    o_done
);
    import cpt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ID_W-1:0]  mem_lo [TABLE_DEPTH];
    logic [ID_W-1:0]  mem_hi [TABLE_DEPTH];

    logic [ID_W-1:0]  r_lo;
    logic [ID_W-1:0]  r_hi;
    logic             r_ensure;
    logic             r_bad;
    logic [CNT_W-1:0] r_addr;
    logic [CNT_W-1:0] r_count;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [ID_W-1:0]  r_rd_lo;
    logic [ID_W-1:0]  r_rd_hi;
    t_rsp             r_rsp;
    logic             r_done;

    logic             a_less;
    logic             issue;
    logic             full;
    logic [IDX_W-1:0] res_idx;
    logic [IDX_W+IDX_OUT_W-1:0] res_ext;

    assign a_less = (i_req.id_a < i_req.id_b);
    assign issue  = i_ctl.scan && (r_addr < r_count);
    assign full   = (r_count == CNT_W'(TABLE_DEPTH));

    assign o_stat.match    = r_rd_vld && (r_rd_lo == r_lo) && (r_rd_hi == r_hi);
    assign o_stat.scan_end = !r_rd_vld && (r_addr >= r_count);
    assign o_stat.bad      = r_bad;
    assign o_stat.ensure   = r_ensure;
    assign o_stat.full     = full;

    always_comb begin
        case (i_ctl.code)
            ST_FOUND:    res_idx = r_rd_idx;
            ST_INSERTED: res_idx = r_count[IDX_W-1:0];
            default:     res_idx = '0;
        endcase
    end

    assign res_ext = {{IDX_OUT_W{1'b0}}, res_idx};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_lo     <= a_less ? i_req.id_a : i_req.id_b;
            r_hi     <= a_less ? i_req.id_b : i_req.id_a;
            r_ensure <= i_req.cmd;
            r_bad    <= (i_req.id_a == '0) || (i_req.id_b == '0) || (i_req.id_a == i_req.id_b);
        end
        if (issue) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (i_ctl.finish) begin
            r_rsp.status      <= i_ctl.code;
            r_rsp.entry_index <= res_ext[IDX_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_ctl.finish;
            if (i_ctl.load) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_ctl.write) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            mem_lo[r_count[IDX_W-1:0]] <= r_lo;
            mem_hi[r_count[IDX_W-1:0]] <= r_hi;
        end
        if (issue) begin
            r_rd_lo <= mem_lo[r_addr[IDX_W-1:0]];
            r_rd_hi <= mem_hi[r_addr[IDX_W-1:0]];
        end
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    ap_done_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |=> o_done)
        else $error("finished request gave no result transfer");

    ap_write_grows_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.write |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance the entry count");

endmodule

`default_nettype wire

>>> hdl/contact_pair_table_unit.sv
// Top level of the contact pair table unit: controller plus datapath.
//
//   Channel   Signals              Direction   Transfer when
//   request   start, busy, i_req   in          start high and busy low at a clock edge
//   result    o_done, o_rsp        out         o_done high, one cycle, no back-pressure
//
// A request scans the stored pairs in order from index 0 and ends at the first match, after
// the last stored pair when none matches, or at once when the table is empty; an invalid
// ensure ends without a scan. The scan reads one stored pair per cycle from the pair memory
// through a registered read port, and the result is registered.
// Synchronous active-low reset empties the table; busy falls in the result cycle, so the
// next request may be accepted at the edge that ends it. Results are never stalled.
`timescale 1ns / 1ps
`default_nettype none

module contact_pair_table_unit #(
    parameter int TABLE_DEPTH = cpt_pkg::DEPTH_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cpt_pkg::t_req  i_req,
    output cpt_pkg::t_rsp       o_rsp,
    output logic                o_done
);
    import cpt_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;

    cpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    cpt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the contact pair table unit.
`timescale 1ns / 1ps

module tb;
    import cpt_pkg::*;

    localparam int TBL_DEPTH = DEPTH_DEFAULT;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    t_rsp o_rsp;
    logic o_done;

    contact_pair_table_unit #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_rsp(o_rsp),
        .o_done(o_done)
    );

    // Predicted contents of the pair table.
    logic [ID_W-1:0] pair_lo [0:TBL_DEPTH-1];
    logic [ID_W-1:0] pair_hi [0:TBL_DEPTH-1];
    int pair_count;

    // Pairs that the planned requests will have stored, used only to shape stimulus.
    logic [ID_W-1:0] plan_lo [$];
    logic [ID_W-1:0] plan_hi [$];

    t_req req_backlog [$];
    t_rsp rsp_due [$];
    t_rsp want;
    int n_total;
    int n_issued;
    int n_accepted;
    int n_errors;
    int rst_cycles;
    int gap_left;
    bit burst;

    function automatic t_rsp resolve_pair(t_req r);
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        int hit;
        t_rsp rsp;
        lo = (r.id_a < r.id_b) ? r.id_a : r.id_b;
        hi = (r.id_a < r.id_b) ? r.id_b : r.id_a;
        hit = -1;
        for (int i = 0; i < pair_count; i++) begin
            if (hit < 0 && pair_lo[i] == lo && pair_hi[i] == hi) begin
                hit = i;
            end
        end
        rsp.entry_index = '0;
        if (!r.cmd) begin
            rsp.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
        end else if (r.id_a == '0 || r.id_b == '0 || r.id_a == r.id_b) begin
            rsp.status = ST_INVALID;
            hit = -1;
        end else if (hit >= 0) begin
            rsp.status = ST_FOUND;
        end else if (pair_count >= TBL_DEPTH) begin
            rsp.status = ST_FULL;
        end else begin
            pair_lo[pair_count] = lo;
            pair_hi[pair_count] = hi;
            hit = pair_count;
            pair_count++;
            rsp.status = ST_INSERTED;
        end
        if (hit >= 0) begin
            rsp.entry_index = hit[IDX_OUT_W-1:0];
        end
        return rsp;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] edgy_id();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 64'd1;
            2: return ID_MAX;
            3: return ID_MAX - 64'd1;
            4: return 64'h8000_0000_0000_0000;
            5: return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return rand_id();
        endcase
    endfunction

    task automatic queue_request(input logic c, input logic [ID_W-1:0] a,
                                 input logic [ID_W-1:0] b);
        t_req r;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        bit known;
        r.cmd = c;
        r.id_a = a;
        r.id_b = b;
        req_backlog.insert(req_backlog.size(), r);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        known = 0;
        foreach (plan_lo[i]) begin
            if (plan_lo[i] == lo && plan_hi[i] == hi) known = 1;
        end
        if (c && a != '0 && b != '0 && a != b && !known && plan_lo.size() < TBL_DEPTH) begin
            plan_lo.insert(plan_lo.size(), lo);
            plan_hi.insert(plan_hi.size(), hi);
        end
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            if (rst_cycles == 6) i_rst_n <= 1'b1;
            rst_cycles++;
        end else if (start) begin
            if (n_accepted == n_issued) begin
                if ($urandom_range(0, 29) == 0) burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 4);
                if (gap_left == 0 && req_backlog.size() != 0) begin
                    i_req <= req_backlog.pop_front();
                    n_issued++;
                end else begin
                    start <= 1'b0;
                end
            end
        end else if (gap_left != 0) begin
            gap_left--;
        end else if (req_backlog.size() != 0) begin
            i_req <= req_backlog.pop_front();
            start <= 1'b1;
            n_issued++;
        end
    end

    // Monitor: results and request transfers are sampled on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (rsp_due.size() == 0) begin
                    note_error($sformatf("unexpected result: status %0d index %0d",
                                         o_rsp.status, o_rsp.entry_index));
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp.status !== want.status
                        || o_rsp.entry_index !== want.entry_index) begin
                        note_error($sformatf("expected status %0d index %0d, got %0d %0d",
                                             want.status, want.entry_index,
                                             o_rsp.status, o_rsp.entry_index));
                    end
                end
            end
            if (start && !busy) begin
                rsp_due.insert(rsp_due.size(), resolve_pair(i_req));
                n_accepted++;
            end
        end
    end

    initial begin
        int kind;
        int k;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        pair_count = 0;
        n_issued = 0;
        n_accepted = 0;
        n_errors = 0;
        rst_cycles = 0;
        gap_left = 0;
        burst = 0;

        // Directed part: empty table, rejected ids, extremes, both id orders.
        queue_request(1'b0, 64'd1, 64'd2);
        queue_request(1'b1, 64'd0, 64'd5);
        queue_request(1'b1, 64'd5, 64'd0);
        queue_request(1'b1, 64'd0, 64'd0);
        queue_request(1'b1, 64'd7, 64'd7);
        queue_request(1'b1, ID_MAX, 64'd1);
        queue_request(1'b0, 64'd1, ID_MAX);
        queue_request(1'b0, ID_MAX, 64'd1);
        queue_request(1'b1, 64'd1, ID_MAX);
        queue_request(1'b1, ID_MAX, ID_MAX - 64'd1);
        queue_request(1'b0, 64'd0, 64'd0);
        queue_request(1'b0, 64'd9, 64'd9);
        queue_request(1'b0, 64'd0, ID_MAX);
        queue_request(1'b1, ID_MAX - 64'd1, ID_MAX);
        queue_request(1'b1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_request(1'b0, 64'd1, ID_MAX - 64'd1);
        queue_request(1'b1, ID_MAX, ID_MAX);

        // Random part: mostly stored pairs and near misses, so that the table fills
        // and matches land at every index, then the full table is exercised.
        for (int n = 0; n < 1100; n++) begin
            kind = $urandom_range(0, 99);
            k = (plan_lo.size() != 0) ? $urandom_range(0, plan_lo.size() - 1) : 0;
            if (kind < 40 && plan_lo.size() != 0) begin
                a = plan_lo[k];
                b = plan_hi[k];
                if ($urandom_range(0, 1)) queue_request(1'($urandom_range(0, 1)), a, b);
                else queue_request(1'($urandom_range(0, 1)), b, a);
            end else if (kind < 46) begin
                queue_request(1'b1, rand_id(), rand_id());
            end else if (kind < 58) begin
                queue_request(1'b0, rand_id(), rand_id());
            end else if (kind < 70) begin
                a = rand_id();
                case ($urandom_range(0, 3))
                    0: queue_request(1'($urandom_range(0, 1)), '0, a);
                    1: queue_request(1'($urandom_range(0, 1)), a, '0);
                    2: queue_request(1'($urandom_range(0, 1)), '0, '0);
                    default: queue_request(1'($urandom_range(0, 1)), a, a);
                endcase
            end else if (kind < 80 && plan_lo.size() != 0) begin
                a = $urandom_range(0, 1) ? plan_lo[k] : plan_hi[k];
                b = rand_id();
                if ($urandom_range(0, 1)) queue_request($urandom_range(0, 3) == 0, a, b);
                else queue_request($urandom_range(0, 3) == 0, b, a);
            end else begin
                queue_request(1'($urandom_range(0, 1)), edgy_id(), edgy_id());
            end
        end
        n_total = req_backlog.size();

        while (n_accepted < n_total || rsp_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
